>>> src/jxhdp_pkg.sv
// ----------------------------------------------------------------------------
// jxhdp_pkg
// Shared types and constants of the image header dimension parser.
// ----------------------------------------------------------------------------
package jxhdp_pkg;

  // "WMPHOTO", the seven bytes in front of the terminating zero byte
  localparam logic [55:0] MAGIC_WORD = 56'h574D50484F544F;

  localparam int unsigned OFF_W = 5;

  // header offsets counted from the first magic byte
  localparam logic [OFF_W-1:0] MAGIC_LAST   = 5'd7;
  localparam logic [OFF_W-1:0] OFF_FORM     = 5'd10;
  localparam logic [OFF_W-1:0] OFF_WIDTH    = 5'd12;
  localparam logic [OFF_W-1:0] OFF_HEIGHT_S = 5'd14;
  localparam logic [OFF_W-1:0] OFF_HEIGHT_L = 5'd16;
  localparam logic [OFF_W-1:0] END_S        = 5'd15;
  localparam logic [OFF_W-1:0] END_L        = 5'd19;

  // bit of the form byte that selects the short header
  localparam int unsigned FORM_BIT = 7;

  typedef enum logic [1:0] {
    STATUS_FOUND     = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_TRUNCATED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'b001,
    PH_HEADER = 3'b010,
    PH_IGNORE = 3'b100
  } phase_e;

  typedef struct packed {
    status_e     status;
    logic [32:0] image_width;
    logic [32:0] image_height;
  } result_t;

endpackage

>>> src/jxhdp_if.sv
// ----------------------------------------------------------------------------
// jxhdp byte and result channels
// Valid/ready channels carrying input bytes and dimension results.
// ----------------------------------------------------------------------------
interface jxhdp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface jxhdp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [32:0] image_width;
  logic [32:0] image_height;

  modport source (output valid, output status, output image_width,
                  output image_height, input ready);
  modport sink   (input valid, input status, input image_width,
                  input image_height, output ready);
endinterface

>>> src/jxhdp_parser.sv
// ----------------------------------------------------------------------------
// jxhdp_parser
// Per-byte magic search and header field assembly; one word per cycle in which step_valid_i is high.
// ----------------------------------------------------------------------------
module jxhdp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_valid_i,
  input  logic [7:0]        data_byte_i,
  input  logic              is_last_i,
  output logic              res_valid_o,
  output jxhdp_pkg::result_t res_o
);

  logic [55:0]                 recent_q, recent_d;
  jxhdp_pkg::phase_e           phase_q, phase_d;
  logic [jxhdp_pkg::OFF_W-1:0] offset_q, offset_d;
  logic                        short_q, short_d;
  logic [31:0]                 width_q, width_d;
  logic [31:0]                 height_q, height_d;

  logic [jxhdp_pkg::OFF_W-1:0] off;
  logic [jxhdp_pkg::OFF_W-1:0] h_start;
  logic [jxhdp_pkg::OFF_W-1:0] h_end;
  logic                        magic_hit;

  // header position of the current word and field windows
  assign off       = offset_q + 5'd1;
  assign h_start   = short_q ? jxhdp_pkg::OFF_HEIGHT_S : jxhdp_pkg::OFF_HEIGHT_L;
  assign h_end     = short_q ? jxhdp_pkg::END_S : jxhdp_pkg::END_L;
  assign magic_hit = (data_byte_i == 8'd0) && (recent_q == jxhdp_pkg::MAGIC_WORD);

  // next state and result
  always_comb begin
    recent_d    = recent_q;
    phase_d     = phase_q;
    offset_d    = offset_q;
    short_d     = short_q;
    width_d     = width_q;
    height_d    = height_q;
    res_valid_o = 1'b0;
    res_o       = '{status: jxhdp_pkg::STATUS_NOT_FOUND,
                    image_width: 33'd0, image_height: 33'd0};
    if (step_valid_i) begin
      case (phase_q)
        jxhdp_pkg::PH_SEARCH: begin
          if (magic_hit && !is_last_i) begin
            phase_d  = jxhdp_pkg::PH_HEADER;
            offset_d = jxhdp_pkg::MAGIC_LAST;
          end
          recent_d = {recent_q[47:0], data_byte_i};
          if (is_last_i) begin
            res_valid_o  = 1'b1;
            res_o.status = jxhdp_pkg::STATUS_NOT_FOUND;
          end
        end
        jxhdp_pkg::PH_HEADER: begin
          offset_d = off;
          if (off == jxhdp_pkg::OFF_FORM) begin
            short_d = data_byte_i[jxhdp_pkg::FORM_BIT];
          end
          if (off >= jxhdp_pkg::OFF_WIDTH && off < h_start) begin
            width_d = {width_q[23:0], data_byte_i};
          end
          if (off >= h_start && off <= h_end) begin
            height_d = {height_q[23:0], data_byte_i};
          end
          if (off == h_end) begin
            res_valid_o        = 1'b1;
            res_o.status       = jxhdp_pkg::STATUS_FOUND;
            res_o.image_width  = {1'b0, width_d} + 33'd1;
            res_o.image_height = {1'b0, height_d} + 33'd1;
            phase_d            = jxhdp_pkg::PH_IGNORE;
          end else if (is_last_i) begin
            res_valid_o  = 1'b1;
            res_o.status = jxhdp_pkg::STATUS_TRUNCATED;
          end
        end
        jxhdp_pkg::PH_IGNORE: begin
          phase_d = jxhdp_pkg::PH_IGNORE;
        end
        default: begin
          phase_d = jxhdp_pkg::PH_SEARCH;
        end
      endcase
      // buffer boundary returns everything to the idle search
      if (is_last_i) begin
        recent_d = '0;
        phase_d  = jxhdp_pkg::PH_SEARCH;
        offset_d = '0;
        short_d  = 1'b0;
        width_d  = '0;
        height_d = '0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      phase_q  <= jxhdp_pkg::PH_SEARCH;
      offset_q <= '0;
      short_q  <= 1'b0;
      width_q  <= '0;
      height_q <= '0;
    end else begin
      recent_q <= recent_d;
      phase_q  <= phase_d;
      offset_q <= offset_d;
      short_q  <= short_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // found results only come out of the header phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == jxhdp_pkg::STATUS_FOUND |-> phase_q == jxhdp_pkg::PH_HEADER)
    else $error("found result outside header phase");

  // a last mark always returns to a clean search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_valid_i && is_last_i |=> phase_q == jxhdp_pkg::PH_SEARCH && offset_q == '0
      && width_q == '0 && height_q == '0)
    else $error("state not cleared at buffer end");

  // no second result for a buffer once dimensions were given
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_valid_i && phase_q == jxhdp_pkg::PH_IGNORE |-> !res_valid_o)
    else $error("result while ignoring");

  // failed searches report zero dimensions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != jxhdp_pkg::STATUS_FOUND
      |-> res_o.image_width == 33'd0 && res_o.image_height == 33'd0)
    else $error("nonzero dimensions on failure");

  // header offset stays within the long header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == jxhdp_pkg::PH_HEADER |-> offset_q >= jxhdp_pkg::MAGIC_LAST
      && offset_q < jxhdp_pkg::END_L)
    else $error("header offset out of range");

endmodule

>>> src/jxhdp_core.sv
// ----------------------------------------------------------------------------
// jpegxr_header_dimension_parser_core
// Finds the image header in a byte stream and reports the picture size.
// ----------------------------------------------------------------------------
// Usage:
//   in_byte_i carries one buffer byte per word, is_last marking the final
//   byte of each buffer. out_result_o carries at most one word per buffer:
//   status (found, magic not found, header truncated) and the width and
//   height, each stored field plus one in 33 bits, zero unless found.
//   Throughput is one byte per cycle while the receiver keeps up; the byte
//   search and field shift is a single compare-and-shift step between the
//   input register and the result register, which takes a result word as
//   its final byte is processed. An input register and an output register
//   decouple the channels, so a byte is taken while a finished result
//   still waits. When the receiver stalls, the held byte is processed only
//   once the result register frees, and in_byte_i.ready drops once the
//   input register is also occupied. Reset empties both registers and
//   returns the parser to the magic search with all fields cleared.
// ----------------------------------------------------------------------------
module jpegxr_header_dimension_parser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  jxhdp_byte_if.sink         in_byte_i,
  jxhdp_result_if.source     out_result_o
);

  logic                in_valid_q;
  logic [7:0]          in_byte_q;
  logic                in_last_q;
  logic                out_valid_q;
  jxhdp_pkg::result_t  out_q;

  logic                out_free;
  logic                step;
  logic                res_valid;
  jxhdp_pkg::result_t  res;

  // handshake control
  assign out_free        = !out_valid_q || out_result_o.ready;
  assign step            = in_valid_q && out_free;
  assign in_byte_i.ready = !in_valid_q || out_free;

  jxhdp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (step),
    .data_byte_i  (in_byte_q),
    .is_last_i    (in_last_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_byte_i.valid && in_byte_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_byte_i.valid && in_byte_i.ready) begin
      in_byte_q <= in_byte_i.data_byte;
      in_last_q <= in_byte_i.is_last;
    end
    if (res_valid) begin
      out_q <= res;
    end
  end

  // result channel
  assign out_result_o.valid        = out_valid_q;
  assign out_result_o.status       = out_q.status;
  assign out_result_o.image_width  = out_q.image_width;
  assign out_result_o.image_height = out_q.image_height;

endmodule

>>> sim/jpegxr_header_dimension_parser_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jpegxr_header_dimension_parser_core_test
// Self-checking bench for the image header dimension parser. Buffers of
// bytes, directed and random, are streamed into the block. A shadow of the
// parser computes the status and dimensions that each buffer should yield,
// and every result word is compared against the oldest expectation. Both
// channels idle at random, and the receiver holds off once for a long
// stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------

class dim_tracker;
  logic [55:0]         window;
  jxhdp_pkg::phase_e   phase;
  logic [4:0]          hdr_off;
  logic                short_hdr;
  logic [31:0]         width_m1;
  logic [31:0]         height_m1;
  jxhdp_pkg::result_t  pending_dims[$];
  int unsigned         errors;

  function new();
    clear();
    errors = 0;
  endfunction

  // every last mark returns the parser to the magic search
  function void clear();
    window    = '0;
    phase     = jxhdp_pkg::PH_SEARCH;
    hdr_off   = '0;
    short_hdr = 1'b0;
    width_m1  = '0;
    height_m1 = '0;
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // shadow the parser for one accepted byte word
  function void take_byte(logic [7:0] b, logic last);
    logic [4:0]         off;
    logic [4:0]         h_start;
    logic [4:0]         h_end;
    jxhdp_pkg::result_t r;
    r = '0;
    case (phase)
      jxhdp_pkg::PH_SEARCH: begin
        if (b == 8'h00 && window == jxhdp_pkg::MAGIC_WORD && !last) begin
          phase   = jxhdp_pkg::PH_HEADER;
          hdr_off = jxhdp_pkg::MAGIC_LAST;
        end
        window = {window[47:0], b};
        if (last) begin
          r.status = jxhdp_pkg::STATUS_NOT_FOUND;
          pending_dims.push_back(r);
        end
      end
      jxhdp_pkg::PH_HEADER: begin
        off     = hdr_off + 5'd1;
        h_start = short_hdr ? jxhdp_pkg::OFF_HEIGHT_S : jxhdp_pkg::OFF_HEIGHT_L;
        h_end   = short_hdr ? jxhdp_pkg::END_S : jxhdp_pkg::END_L;
        hdr_off = off;
        if (off == jxhdp_pkg::OFF_FORM) short_hdr = b[jxhdp_pkg::FORM_BIT];
        if (off >= jxhdp_pkg::OFF_WIDTH && off < h_start) width_m1 = {width_m1[23:0], b};
        if (off >= h_start && off <= h_end) height_m1 = {height_m1[23:0], b};
        if (off == h_end) begin
          r.status       = jxhdp_pkg::STATUS_FOUND;
          r.image_width  = {1'b0, width_m1} + 33'd1;
          r.image_height = {1'b0, height_m1} + 33'd1;
          pending_dims.push_back(r);
          phase = jxhdp_pkg::PH_IGNORE;
        end else if (last) begin
          r.status = jxhdp_pkg::STATUS_TRUNCATED;
          pending_dims.push_back(r);
        end
      end
      default: ;
    endcase
    if (last) clear();
  endfunction

  // compare one accepted result word with the oldest expectation
  function void check_word(logic [1:0] st, logic [32:0] w, logic [32:0] h);
    jxhdp_pkg::result_t want;
    if (pending_dims.size() == 0) begin
      flag($sformatf("result word with none expected: status=%0d w=%0d h=%0d",
                     st, w, h));
      return;
    end
    want = pending_dims.pop_front();
    if (st !== want.status)
      flag($sformatf("status: expected %0d, got %0d", want.status, st));
    if (w !== want.image_width)
      flag($sformatf("width: expected %0d, got %0d", want.image_width, w));
    if (h !== want.image_height)
      flag($sformatf("height: expected %0d, got %0d", want.image_height, h));
  endfunction
endclass

module jpegxr_header_dimension_parser_core_test;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PHASE_BYTES    = 430;

  logic clk_i;
  logic rst_ni;

  jxhdp_byte_if   in_byte ();
  jxhdp_result_if out_result ();

  jpegxr_header_dimension_parser_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_byte_i    (in_byte),
    .out_result_o (out_result)
  );

  dim_tracker sb = new();

  int         send_idle_pct;
  int         recv_idle_pct;
  int         hold_asks;
  int         hold_done;
  int         hold_left;
  int         idle_cycles;
  int         bytes_sent;
  logic [7:0] frame_q[$];

  always #HALF_PERIOD clk_i = ~clk_i;

  // input words into the shadow parser
  always @(posedge clk_i) begin
    if (in_byte.valid && in_byte.ready)
      sb.take_byte(in_byte.data_byte, in_byte.is_last);
  end

  // result words against expectations
  always @(posedge clk_i) begin
    if (out_result.valid && out_result.ready)
      sb.check_word(out_result.status, out_result.image_width, out_result.image_height);
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_result.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_done) begin
      out_result.ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= hold_asks;
    end else begin
      out_result.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_byte.valid && in_byte.ready) ||
        (out_result.valid && out_result.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one byte word, with random gaps in front of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_byte.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_byte.valid     <= 1'b1;
    in_byte.data_byte <= b;
    in_byte.is_last   <= last;
    @(posedge clk_i);
    while (!in_byte.ready) @(posedge clk_i);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++)
      send_byte(frame_q[i], i == frame_q.size() - 1);
    bytes_sent += frame_q.size();
    frame_q.delete();
  endtask

  function automatic void put_magic();
    for (int i = 6; i >= 0; i--) frame_q.push_back(jxhdp_pkg::MAGIC_WORD[i*8 +: 8]);
    frame_q.push_back(8'h00);
  endfunction

  // magic, then offsets 8 to the end of the height field
  function automatic void put_header(logic short_form, logic [31:0] w_m1, logic [31:0] h_m1);
    put_magic();
    frame_q.push_back(8'($urandom));
    frame_q.push_back(8'($urandom));
    frame_q.push_back({short_form, 7'($urandom)});
    frame_q.push_back(8'($urandom));
    if (short_form) begin
      frame_q.push_back(w_m1[15:8]);
      frame_q.push_back(w_m1[7:0]);
      frame_q.push_back(h_m1[15:8]);
      frame_q.push_back(h_m1[7:0]);
    end else begin
      for (int i = 3; i >= 0; i--) frame_q.push_back(w_m1[i*8 +: 8]);
      for (int i = 3; i >= 0; i--) frame_q.push_back(h_m1[i*8 +: 8]);
    end
  endfunction

  function automatic logic [31:0] pick_field();
    case ($urandom_range(5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic void put_noise(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0:       frame_q.push_back(jxhdp_pkg::MAGIC_WORD[$urandom_range(6)*8 +: 8]);
        1:       frame_q.push_back(8'h00);
        default: frame_q.push_back(8'($urandom));
      endcase
    end
  endfunction

  // mostly well-formed buffers with random content, the rest broken or noise
  task automatic random_frame();
    int   kind;
    int   cut;
    logic short_form;
    kind       = $urandom_range(99);
    short_form = 1'($urandom_range(1));
    if ($urandom_range(2) == 0) put_noise($urandom_range(1, 5));
    if ($urandom_range(4) == 0)
      for (int i = 6; i > $urandom_range(2, 6); i--)
        frame_q.push_back(jxhdp_pkg::MAGIC_WORD[i*8 +: 8]);
    if (kind < 60) begin
      put_header(short_form, pick_field(), pick_field());
      if ($urandom_range(4) == 0) put_magic();
      put_noise($urandom_range(0, 4));
    end else if (kind < 75) begin
      // header cut short, possibly right after the zero byte
      put_header(short_form, pick_field(), pick_field());
      cut = $urandom_range(1, short_form ? 8 : 12);
      repeat (cut) void'(frame_q.pop_back());
    end else if (kind < 85) begin
      // magic letters followed by a nonzero byte
      for (int i = 6; i >= 0; i--) frame_q.push_back(jxhdp_pkg::MAGIC_WORD[i*8 +: 8]);
      frame_q.push_back(8'($urandom_range(1, 255)));
      put_noise($urandom_range(0, 6));
    end else begin
      put_noise($urandom_range(1, 12));
    end
    if (frame_q.size() == 0) frame_q.push_back(8'($urandom));
    send_frame();
  endtask

  task automatic run_random(int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) random_frame();
  endtask

  task automatic run_directed();
    // single-byte buffer
    frame_q.push_back(8'h00);
    send_frame();
    // buffer shorter than the magic
    frame_q.push_back(8'hFF);
    frame_q.push_back(jxhdp_pkg::MAGIC_WORD[55:48]);
    send_frame();
    // magic whose zero byte is the final byte
    put_magic();
    send_frame();
    // header cut off right after the magic
    put_magic();
    frame_q.push_back(8'hA5);
    send_frame();
    // short form, largest fields, ending exactly on the last mark
    put_header(1'b1, 32'h0000_FFFF, 32'h0000_FFFF);
    send_frame();
    // long form, largest fields, trailing bytes ignored
    put_header(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h00);
    send_frame();
    // long form, zero fields, a second header after the result is ignored
    put_header(1'b0, 32'h0, 32'h0);
    put_header(1'b1, 32'h1234, 32'h5678);
    frame_q.push_back(8'h00);
    send_frame();
    // short form, zero fields
    put_header(1'b1, 32'h0, 32'h0);
    send_frame();
    // long form cut one byte before the end of the height field
    put_header(1'b0, 32'h89AB_CDEF, 32'h0123_4567);
    void'(frame_q.pop_back());
    send_frame();
    // magic letters followed by a nonzero byte never match
    for (int i = 6; i >= 0; i--) frame_q.push_back(jxhdp_pkg::MAGIC_WORD[i*8 +: 8]);
    frame_q.push_back(8'h01);
    put_header(1'b1, 32'h0000_0001, 32'h0000_0002);
    send_frame();
    // partial magic in front of a real one
    frame_q.push_back(jxhdp_pkg::MAGIC_WORD[55:48]);
    for (int i = 6; i >= 2; i--) frame_q.push_back(jxhdp_pkg::MAGIC_WORD[i*8 +: 8]);
    put_header(1'b0, 32'h0000_0100, 32'h00FF_0000);
    send_frame();
    // long buffer with no magic at all
    repeat (40) frame_q.push_back(8'hFF);
    send_frame();
  endtask

  initial begin
    clk_i                = 1'b0;
    rst_ni               = 1'b0;
    in_byte.valid        = 1'b0;
    in_byte.data_byte    = 8'h00;
    in_byte.is_last      = 1'b0;
    out_result.ready     = 1'b0;
    send_idle_pct        = 9;
    recv_idle_pct        = 77;
    hold_asks            = 0;
    hold_done            = 0;
    hold_left            = 0;
    idle_cycles          = 0;
    bytes_sent           = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender mostly busy, receiver mostly stalled
    run_directed();
    run_random(PHASE_BYTES);

    // sender mostly idle, receiver mostly ready
    send_idle_pct = 77;
    recv_idle_pct = 9;
    run_random(PHASE_BYTES);

    // no idling, with one long receiver hold-off to back up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asks++;
    run_random(PHASE_BYTES);
    in_byte.valid <= 1'b0;

    // drain outstanding results, then watch for stray words
    while (sb.pending_dims.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> jpegxr_header_dimension_parser_core.f
src/jxhdp_pkg.sv
src/jxhdp_if.sv
src/jxhdp_parser.sv
src/jxhdp_core.sv
sim/jpegxr_header_dimension_parser_core_test.sv
